// ===== design/acss_pkg.sv =====
// ----------------------------------------------------------------------------
// acss_pkg: shared types and constants of the alarm clock display block
// Holds the time constants, the input codes and the queue entry that the
// front part hands to the display back part.
// ----------------------------------------------------------------------------
package acss_pkg;

  // Time constants, in seconds
  localparam int unsigned DaySeconds  = 86400;
  localparam int unsigned HourSeconds = 3600;
  localparam int unsigned MinSeconds  = 60;

  // Widths
  localparam int unsigned SecW  = 17;  // seconds of day, 0..86399
  localparam int unsigned HourW = 5;   // hours, 0..23
  localparam int unsigned RemW  = 12;  // seconds within an hour, 0..3599
  localparam int unsigned MinW  = 6;   // minutes or seconds, 0..59

  // Letter code shown in the upper digits in letter format
  localparam logic [6:0] LetterCode = 7'b1000000;

  // Item operation codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_KEY  = 1'b1
  } acss_op_e;

  // Key bitmap codes
  typedef enum logic [1:0] {
    KEY_NONE = 2'd0,
    KEY_HOUR = 2'd1,
    KEY_MIN  = 2'd2,
    KEY_BOTH = 2'd3
  } acss_key_e;

  // Display format register codes
  typedef enum logic {
    FMT_LETTERS = 1'b0,
    FMT_12H     = 1'b1
  } acss_fmt_e;

  // One classified item waiting for display conversion
  typedef struct packed {
    logic            alarm_led;
    logic            beep;
    logic            fmt;
    logic [SecW-1:0] shown;
  } acss_entry_t;

endpackage

// ===== design/acss_item_if.sv =====
// ----------------------------------------------------------------------------
// acss_item_if: input item channel
// Valid/ready channel carrying one tick or key event with the switch states.
// ----------------------------------------------------------------------------
interface acss_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] keys;
  logic       alarm_enable;
  logic       set_alarm_mode;
  logic       set_time_mode;

  modport source (
    output valid, op, keys, alarm_enable, set_alarm_mode, set_time_mode,
    input  ready
  );
  modport sink (
    input  valid, op, keys, alarm_enable, set_alarm_mode, set_time_mode,
    output ready
  );
endinterface

// ===== design/acss_result_if.sv =====
// ----------------------------------------------------------------------------
// acss_result_if: result item channel
// Valid/ready channel carrying the indicator flags and the segment codes.
// ----------------------------------------------------------------------------
interface acss_result_if;
  logic        valid;
  logic        ready;
  logic        alarm_led;
  logic        beep_start;
  logic [15:0] upper_digits;
  logic [31:0] lower_digits;

  modport source (
    output valid, alarm_led, beep_start, upper_digits, lower_digits,
    input  ready
  );
  modport sink (
    input  valid, alarm_led, beep_start, upper_digits, lower_digits,
    output ready
  );
endinterface

// ===== design/acss_cfg_if.sv =====
// ----------------------------------------------------------------------------
// acss_cfg_if: configuration write channel
// Valid/ready channel carrying the display format register value.
// ----------------------------------------------------------------------------
interface acss_cfg_if;
  logic valid;
  logic ready;
  logic display_format;

  modport source (
    output valid, display_format,
    input  ready
  );
  modport sink (
    input  valid, display_format,
    output ready
  );
endinterface

// ===== design/acss_front.sv =====
// ----------------------------------------------------------------------------
// acss_front: item classifier and clock state
// Accepts ticks and key events, updates the time and alarm counters, raises
// the beep flag and pushes the value to show into the queue.
// ----------------------------------------------------------------------------
module acss_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  acss_item_if.sink            in_i,
  acss_cfg_if.sink             cfg_i,
  input  logic                 full_i,
  output logic                 push_o,
  output acss_pkg::acss_entry_t entry_o
);
  import acss_pkg::*;

  logic [SecW-1:0] tod_q, tod_d;
  logic [SecW-1:0] alarm_q, alarm_d;
  logic            fmt_q;
  logic [SecW-1:0] tod_inc, tod_key, alarm_key;
  logic            accept;
  logic            is_tick;

  // Add the key increment, drop to zero on overflow past the day
  function automatic logic [SecW-1:0] add_wrap(logic [SecW-1:0] t, logic [1:0] k);
    logic [SecW:0]   sum;
    logic [RemW-1:0] inc;
    case (acss_key_e'(k))
      KEY_HOUR: inc = RemW'(HourSeconds);
      KEY_MIN:  inc = RemW'(MinSeconds);
      KEY_BOTH: inc = RemW'(HourSeconds + MinSeconds);
      default:  inc = '0;
    endcase
    sum = {1'b0, t} + (SecW+1)'(inc);
    return (sum >= (SecW+1)'(DaySeconds)) ? '0 : sum[SecW-1:0];
  endfunction

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign is_tick     = (acss_op_e'(in_i.op) == OP_TICK);

  // Candidate next values
  assign tod_inc   = (tod_q == SecW'(DaySeconds - 1)) ? '0 : tod_q + SecW'(1);
  assign tod_key   = add_wrap(tod_q, in_i.keys);
  assign alarm_key = add_wrap(alarm_q, in_i.keys);

  // Pick the state update for this item
  always_comb begin
    tod_d   = tod_q;
    alarm_d = alarm_q;
    if (is_tick) begin
      if (!in_i.set_time_mode) tod_d = tod_inc;
    end else if (in_i.set_alarm_mode) begin
      alarm_d = alarm_key;
    end else if (in_i.set_time_mode) begin
      tod_d = tod_key;
    end
  end

  // Build the queue entry
  assign push_o            = accept;
  assign entry_o.alarm_led = in_i.alarm_enable;
  assign entry_o.beep      = is_tick && in_i.alarm_enable && (tod_d == alarm_q);
  assign entry_o.fmt       = fmt_q;
  assign entry_o.shown     = in_i.set_alarm_mode ? alarm_d : tod_d;

  // Hold counters and format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tod_q   <= '0;
      alarm_q <= '0;
      fmt_q   <= FMT_12H;
    end else begin
      if (accept) begin
        tod_q   <= tod_d;
        alarm_q <= alarm_d;
      end
      if (cfg_i.valid && cfg_i.ready) fmt_q <= cfg_i.display_format;
    end
  end

  a_tod_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tod_q < SecW'(DaySeconds))
    else $error("time of day out of range");

  a_alarm_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_q < SecW'(DaySeconds))
    else $error("alarm time out of range");

  a_alarm_key_keeps_tod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_tick && in_i.set_alarm_mode |=> $stable(tod_q))
    else $error("key event in alarm mode changed the time");

endmodule

// ===== design/acss_fifo.sv =====
// ----------------------------------------------------------------------------
// acss_fifo: short queue between classifier and display pipeline
// Register-based first-in first-out buffer of classified entries.
// ----------------------------------------------------------------------------
module acss_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  acss_pkg::acss_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output acss_pkg::acss_entry_t entry_o
);
  import acss_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  acss_entry_t     store_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = store_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop)      count_q <= count_q + CntW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
    end
  end

  // Write the entry store
  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wr_q] <= entry_i;
  end

endmodule

// ===== design/acss_back.sv =====
// ----------------------------------------------------------------------------
// acss_back: seconds-to-segments display pipeline
// Four stages: hours by reciprocal, remainder, minutes by reciprocal, then
// seconds, twelve-hour fold, digit split and segment encoding.
// ----------------------------------------------------------------------------
module acss_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  acss_pkg::acss_entry_t entry_i,
  output logic                  pop_o,
  acss_result_if.source         out_o
);
  import acss_pkg::*;

  // floor(t / 3600) = (t * HourRecip) >> HourShift for t below one day
  localparam int unsigned HourShift = 30;
  localparam int unsigned HourRecip = 298262;
  localparam int unsigned HourProdW = 36;
  // floor(r / 60) = (r * MinRecip) >> MinShift for r below one hour
  localparam int unsigned MinShift  = 20;
  localparam int unsigned MinRecip  = 17477;
  localparam int unsigned MinProdW  = 27;

  // Active-low segment code of one decimal digit
  function automatic logic [6:0] seg7(logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'b1000000;
      4'd1:    s = 7'b1111001;
      4'd2:    s = 7'b0100100;
      4'd3:    s = 7'b0110000;
      4'd4:    s = 7'b0011001;
      4'd5:    s = 7'b0010010;
      4'd6:    s = 7'b0000010;
      4'd7:    s = 7'b1111000;
      4'd8:    s = 7'b0000000;
      4'd9:    s = 7'b0010000;
      default: s = 7'b1111111;
    endcase
    return s;
  endfunction

  // Tens digit of a value below sixty
  function automatic logic [2:0] tens_of(logic [MinW-1:0] v);
    logic [2:0] t;
    t = '0;
    for (int k = 1; k < 6; k++) begin
      if (v >= MinW'(k * 10)) t = 3'(k);
    end
    return t;
  endfunction

  // Two segment bytes, tens in the high byte
  function automatic logic [15:0] two_digits(logic [MinW-1:0] v);
    logic [2:0]      t;
    logic [MinW-1:0] u;
    t = tens_of(v);
    u = v - MinW'(t) * MinW'(10);
    return {1'b0, seg7({1'b0, t}), 1'b0, seg7(u[3:0])};
  endfunction

  logic              v1_q, v2_q, v3_q, v4_q;
  logic              en1, en2, en3, en4;
  acss_entry_t       e1_q;
  logic [HourW-1:0]  h1_q, h2_q, h3_q;
  logic              led2_q, beep2_q, fmt2_q;
  logic              led3_q, beep3_q, fmt3_q;
  logic [RemW-1:0]   r2_q, r3_q;
  logic [MinW-1:0]   m3_q;
  logic [HourProdW-1:0] hour_prod;
  logic [SecW-1:0]   hour_base;
  logic [SecW-1:0]   rem_full;
  logic [MinProdW-1:0]  min_prod;
  logic [RemW-1:0]   min_base;
  logic [RemW-1:0]   sec_full;
  logic [MinW-1:0]   secs;
  logic [HourW-1:0]  hours_shown;
  logic [15:0]       hour_bytes, min_bytes, sec_bytes;
  logic              out_led_q, out_beep_q;
  logic [15:0]       upper_q, upper_d;
  logic [31:0]       lower_q, lower_d;

  // Stall chain: a stage moves when it is empty or its successor moves
  assign en4   = !v4_q || out_o.ready;
  assign en3   = !v3_q || en4;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign pop_o = valid_i && en1;

  // Stage one: hours by reciprocal multiply
  assign hour_prod = HourProdW'(entry_i.shown) * HourProdW'(HourRecip);

  // Stage two: remainder within the hour
  assign hour_base = SecW'(h1_q) * SecW'(HourSeconds);
  assign rem_full  = e1_q.shown - hour_base;

  // Stage three: minutes by reciprocal multiply
  assign min_prod = MinProdW'(r2_q) * MinProdW'(MinRecip);

  // Stage four: seconds, hour fold and segment encoding
  assign min_base    = RemW'(m3_q) * RemW'(MinSeconds);
  assign sec_full    = r3_q - min_base;
  assign secs        = sec_full[MinW-1:0];
  assign hours_shown = (fmt3_q == FMT_12H && h3_q > HourW'(11)) ? h3_q - HourW'(12) : h3_q;
  assign hour_bytes  = two_digits(MinW'(hours_shown));
  assign min_bytes   = two_digits(m3_q);
  assign sec_bytes   = two_digits(secs);

  always_comb begin
    if (fmt3_q == FMT_12H) begin
      upper_d = hour_bytes;
      lower_d = {min_bytes, sec_bytes};
    end else begin
      upper_d = {1'b0, LetterCode, 1'b0, LetterCode};
      lower_d = {hour_bytes, min_bytes};
    end
  end

  // Hold stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk_i) begin
    if (en1) begin
      e1_q <= entry_i;
      h1_q <= hour_prod[HourShift +: HourW];
    end
    if (en2) begin
      h2_q    <= h1_q;
      r2_q    <= rem_full[RemW-1:0];
      led2_q  <= e1_q.alarm_led;
      beep2_q <= e1_q.beep;
      fmt2_q  <= e1_q.fmt;
    end
    if (en3) begin
      h3_q    <= h2_q;
      r3_q    <= r2_q;
      m3_q    <= min_prod[MinShift +: MinW];
      led3_q  <= led2_q;
      beep3_q <= beep2_q;
      fmt3_q  <= fmt2_q;
    end
    if (en4) begin
      out_led_q  <= led3_q;
      out_beep_q <= beep3_q;
      upper_q    <= upper_d;
      lower_q    <= lower_d;
    end
  end

  assign out_o.valid        = v4_q;
  assign out_o.alarm_led    = out_led_q;
  assign out_o.beep_start   = out_beep_q;
  assign out_o.upper_digits = upper_q;
  assign out_o.lower_digits = lower_q;

  a_hours_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> h1_q < HourW'(24))
    else $error("hour quotient out of range");

  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> r2_q < RemW'(HourSeconds))
    else $error("hour remainder out of range");

  a_mins_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> m3_q < MinW'(60) && r3_q - RemW'(m3_q) * RemW'(MinSeconds) < RemW'(60))
    else $error("minute quotient wrong");

endmodule

// ===== design/alarm_clock_seven_segment.sv =====
// ----------------------------------------------------------------------------
// alarm_clock_seven_segment: alarm clock with six-digit segment display
// Keeps the time of day and the alarm time and turns each tick or key event
// into one display result.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one item per handshake: a one-second tick or a key event,
//         with the alarm enable and the two set-mode switches.
//   out_o returns exactly one result per item, in order: alarm lamp, beep
//         start flag and active-low segment codes (tens digit in high byte).
//   cfg_i writes the display format; write it only while no item is in
//         flight. Writes are always taken.
//   An accepted item passes through the queue and then the four-stage conversion
//   pipeline (two reciprocal multiplies); one item per cycle is sustained while
//   out_o does not stall. The classifier updates the counters in the accept cycle.
//   When out_o stalls, the pipeline holds, the queue fills, and in_i.ready
//   drops only once the queue is full.
//   Reset clears time and alarm to zero, selects twelve-hour format and
//   empties the queue and pipeline.
// ----------------------------------------------------------------------------
module alarm_clock_seven_segment #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  acss_item_if.sink     in_i,
  acss_cfg_if.sink      cfg_i,
  acss_result_if.source out_o
);
  import acss_pkg::*;

  logic        push, full, pop, q_valid;
  acss_entry_t push_entry, q_entry;

  // Classify items and keep the clock state
  acss_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Decouple classifier and display pipeline
  acss_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // Convert seconds to segment codes
  acss_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the alarm clock segment display block
// Drives tick and key items with random gaps, stalls the result side at
// random, predicts every display result from its own model of the clock and
// alarm state and compares each field. Both display formats are exercised.
// ----------------------------------------------------------------------------
module tb;
  import acss_pkg::*;

  // Result pipeline depth plus margin, used for settling before config writes
  localparam int unsigned SettleCycles = 8;
  // Total number of items after which the random mix stops
  localparam int unsigned ItemTarget   = 550;

  // Active-low segment codes for the decimal digits
  localparam logic [6:0] SegDigit [0:9] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  typedef struct packed {
    logic        alarm_led;
    logic        beep_start;
    logic [15:0] upper_digits;
    logic [31:0] lower_digits;
  } readout_t;

  logic clk;
  logic rst_n;

  acss_item_if   item_bus ();
  acss_cfg_if    cfg_bus ();
  acss_result_if res_bus ();

  alarm_clock_seven_segment dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (item_bus),
    .cfg_i  (cfg_bus),
    .out_o  (res_bus)
  );

  // Model state
  logic [SecW-1:0] clock_secs;
  logic [SecW-1:0] alarm_secs;
  acss_fmt_e       shown_format;

  readout_t    expected_readouts [$];
  int unsigned mismatches;
  int unsigned items_sent;
  bit          gaps_on;
  bit          stalls_on;

  // Clock generation
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #6ms;
    $display("tb NOT OK");
    $finish;
  end

  // Pause length: mostly none or short, now and then long
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] seg_byte(int unsigned d);
    return {1'b0, SegDigit[d]};
  endfunction

  // Add the key increment, clearing to midnight on overflow
  function automatic logic [SecW-1:0] bump_time(logic [SecW-1:0] t, acss_key_e k);
    int unsigned sum;
    sum = t;
    case (k)
      KEY_HOUR: sum += HourSeconds;
      KEY_MIN:  sum += MinSeconds;
      KEY_BOTH: sum += HourSeconds + MinSeconds;
      default:  sum += 0;
    endcase
    if (sum >= DaySeconds) sum = 0;
    return sum[SecW-1:0];
  endfunction

  // Apply one item to the model state and work out its readout
  function automatic readout_t advance_clock(acss_op_e op, acss_key_e keys, logic en,
                                             logic amode, logic tmode);
    readout_t    r;
    int unsigned secs, hh, mm, ss;
    r.alarm_led  = en;
    r.beep_start = 1'b0;
    if (op == OP_TICK) begin
      if (!tmode) begin
        clock_secs = (clock_secs == DaySeconds - 1) ? '0 : clock_secs + 1'b1;
      end
      r.beep_start = en && (clock_secs == alarm_secs);
    end else if (amode) begin
      alarm_secs = bump_time(alarm_secs, keys);
    end else if (tmode) begin
      clock_secs = bump_time(clock_secs, keys);
    end
    secs = amode ? alarm_secs : clock_secs;
    hh = secs / HourSeconds;
    mm = (secs % HourSeconds) / MinSeconds;
    ss = secs % MinSeconds;
    if (shown_format == FMT_12H) begin
      if (hh > 11) hh -= 12;
      r.upper_digits = {seg_byte(hh / 10), seg_byte(hh % 10)};
      r.lower_digits = {seg_byte(mm / 10), seg_byte(mm % 10),
                        seg_byte(ss / 10), seg_byte(ss % 10)};
    end else begin
      r.upper_digits = {2{1'b0, LetterCode}};
      r.lower_digits = {seg_byte(hh / 10), seg_byte(hh % 10),
                        seg_byte(mm / 10), seg_byte(mm % 10)};
    end
    return r;
  endfunction

  // Present one item, hold it until taken and record its readout
  task automatic send_item(acss_op_e op, acss_key_e keys, logic en, logic amode,
                           logic tmode);
    int unsigned gap;
    gap = gaps_on ? pick_pause() : 0;
    @(negedge clk);
    if (gap != 0) begin
      item_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_bus.valid          = 1'b1;
    item_bus.op             = op;
    item_bus.keys           = keys;
    item_bus.alarm_enable   = en;
    item_bus.set_alarm_mode = amode;
    item_bus.set_time_mode  = tmode;
    do begin
      @(posedge clk);
    end while (!item_bus.ready);
    expected_readouts.push_back(advance_clock(op, keys, en, amode, tmode));
    items_sent++;
  endtask

  // Drop valid and wait until every readout is back
  task automatic drain();
    @(negedge clk);
    item_bus.valid = 1'b0;
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_format(acss_fmt_e f);
    drain();
    @(negedge clk);
    cfg_bus.valid          = 1'b1;
    cfg_bus.display_format = f;
    do begin
      @(posedge clk);
    end while (!cfg_bus.ready);
    shown_format = f;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Set the clock with keys, then tick up to the target (86400 means midnight)
  task automatic chase_to(int unsigned target);
    int unsigned d;
    acss_key_e   k;
    if (target <= clock_secs) begin
      while (clock_secs != 0) begin
        send_item(OP_KEY, KEY_HOUR, 1'($urandom_range(0, 1)), 1'b0, 1'b1);
      end
    end
    while (target - clock_secs > MinSeconds) begin
      d = target - clock_secs;
      k = (d > HourSeconds + MinSeconds) ? KEY_BOTH : (d > HourSeconds) ? KEY_HOUR : KEY_MIN;
      send_item(OP_KEY, k, 1'($urandom_range(0, 1)), 1'b0, 1'b1);
    end
    d = target - clock_secs;
    repeat (d) begin
      send_item(OP_TICK, acss_key_e'($urandom_range(0, 3)), 1'b1,
                1'($urandom_range(0, 4) == 0), 1'b0);
    end
  endtask

  task automatic chase_alarm();
    chase_to((alarm_secs == 0) ? DaySeconds : alarm_secs);
  endtask

  // Random alarm adjustment burst
  task automatic shuffle_alarm(int unsigned n);
    repeat (n) begin
      send_item(OP_KEY, acss_key_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'b1, 1'($urandom_range(0, 1)));
    end
  endtask

  // Mode switches, each key and the frozen compare, in twelve hour format
  task automatic test_mode_keys();
    send_item(OP_TICK, KEY_NONE, 1'b1, 1'b0, 1'b1);  // both zero: beep while frozen
    send_item(OP_KEY,  KEY_BOTH, 1'b0, 1'b0, 1'b0);  // no mode: nothing moves
    send_item(OP_KEY,  KEY_NONE, 1'b1, 1'b0, 1'b1);  // no key
    send_item(OP_KEY,  KEY_HOUR, 1'b0, 1'b1, 1'b0);
    send_item(OP_KEY,  KEY_MIN,  1'b1, 1'b1, 1'b1);  // both modes: alarm only
    send_item(OP_KEY,  KEY_BOTH, 1'b0, 1'b1, 1'b0);
    send_item(OP_TICK, KEY_BOTH, 1'b1, 1'b1, 1'b1);
    send_item(OP_KEY,  KEY_HOUR, 1'b0, 1'b0, 1'b1);
    send_item(OP_KEY,  KEY_BOTH, 1'b1, 1'b0, 1'b1);
    send_item(OP_KEY,  KEY_MIN,  1'b0, 1'b0, 1'b1);
    send_item(OP_TICK, KEY_NONE, 1'b1, 1'b0, 1'b1);  // clock equals alarm
    send_item(OP_TICK, KEY_NONE, 1'b0, 1'b0, 1'b1);
    send_item(OP_TICK, KEY_HOUR, 1'b1, 1'b0, 1'b0);
    send_item(OP_TICK, KEY_MIN,  1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_letter_format();
    write_format(FMT_LETTERS);
    send_item(OP_TICK, KEY_NONE, 1'b1, 1'b0, 1'b0);
    send_item(OP_KEY,  KEY_BOTH, 1'b0, 1'b0, 1'b1);
    send_item(OP_KEY,  KEY_HOUR, 1'b1, 1'b1, 1'b0);
    send_item(OP_TICK, KEY_BOTH, 1'b0, 1'b1, 1'b0);
    write_format(FMT_12H);
  endtask

  // Clock wrap at midnight, alarm key overflow and a match on the wrap
  task automatic test_midnight_rollover();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    chase_to(DaySeconds);
    repeat (3) send_item(OP_TICK, KEY_NONE, 1'b1, 1'b0, 1'b0);
    while (alarm_secs != 0) send_item(OP_KEY, KEY_HOUR, 1'b1, 1'b1, 1'b0);
    chase_alarm();
  endtask

  task automatic test_alarm_match();
    write_format(FMT_LETTERS);
    repeat (3) begin
      shuffle_alarm($urandom_range(1, 20));
      chase_alarm();
    end
  endtask

  // Mixed scenarios in phases with varying format and flow control
  task automatic test_random_mix();
    int unsigned phase, pick, n;
    phase = 0;
    while (items_sent < ItemTarget) begin
      write_format((phase < 2) ? acss_fmt_e'(phase % 2) : acss_fmt_e'($urandom_range(0, 1)));
      gaps_on   = (phase % 3) != 1;
      stalls_on = (phase % 4) != 2;
      for (int p = 0; p < 6 && items_sent < ItemTarget; p++) begin
        pick = $urandom_range(0, 99);
        n    = $urandom_range(1, 12);
        if (pick < 15) begin
          repeat (n) begin
            send_item(acss_op_e'($urandom_range(0, 1)), acss_key_e'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          end
        end else if (pick < 35) begin
          repeat (n) begin
            send_item(($urandom_range(0, 9) == 0) ? OP_TICK : OP_KEY,
                      acss_key_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 4) == 0), 1'b1);
          end
        end else if (pick < 50) begin
          shuffle_alarm(n);
        end else if (pick < 75) begin
          repeat ($urandom_range(1, 40)) begin
            send_item(OP_TICK, acss_key_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 9) == 0));
          end
        end else if (pick < 92) begin
          chase_alarm();
        end else begin
          chase_to(DaySeconds);
        end
      end
      phase++;
    end
  endtask

  // Result side: random back-pressure and field checks
  initial begin : readout_checker
    readout_t    want;
    int unsigned stall_left;
    stall_left    = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        res_bus.ready = 1'b0;
        stall_left--;
      end else if (stalls_on) begin
        stall_left    = pick_pause();
        res_bus.ready = (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end else begin
        res_bus.ready = 1'b1;
      end
      @(posedge clk);
      if (rst_n && res_bus.valid && res_bus.ready) begin
        if (expected_readouts.size() == 0) begin
          $error("readout with none expected");
          mismatches++;
        end else begin
          want = expected_readouts.pop_front();
          if (res_bus.alarm_led !== want.alarm_led) begin
            $error("alarm_led: expected %0h, got %0h", want.alarm_led, res_bus.alarm_led);
            mismatches++;
          end
          if (res_bus.beep_start !== want.beep_start) begin
            $error("beep_start: expected %0h, got %0h", want.beep_start, res_bus.beep_start);
            mismatches++;
          end
          if (res_bus.upper_digits !== want.upper_digits) begin
            $error("upper_digits: expected %0h, got %0h", want.upper_digits,
                   res_bus.upper_digits);
            mismatches++;
          end
          if (res_bus.lower_digits !== want.lower_digits) begin
            $error("lower_digits: expected %0h, got %0h", want.lower_digits,
                   res_bus.lower_digits);
            mismatches++;
          end
        end
      end
    end
  end

  // Sequence of tests
  initial begin : run_tests
    rst_n                   = 1'b0;
    item_bus.valid          = 1'b0;
    item_bus.op             = OP_TICK;
    item_bus.keys           = KEY_NONE;
    item_bus.alarm_enable   = 1'b0;
    item_bus.set_alarm_mode = 1'b0;
    item_bus.set_time_mode  = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.display_format  = FMT_12H;
    clock_secs   = '0;
    alarm_secs   = '0;
    shown_format = FMT_12H;
    mismatches   = 0;
    items_sent   = 0;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_mode_keys();
    test_letter_format();
    test_midnight_rollover();
    test_alarm_match();
    test_random_mix();
    drain();

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
